// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define U8D_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Clocked assertion that also holds during reset.
`define U8D_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hw/rtl/u8d_pkg.sv -----
`timescale 1ns / 1ps

package u8d_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CHAR_W = 16;
  localparam int unsigned COUNT_W = 17;

  localparam int unsigned PEND_DEPTH = 6;
  localparam int unsigned PEND_IDX_W = $clog2(PEND_DEPTH);
  localparam int unsigned PEND_CNT_W = $clog2(PEND_DEPTH + 1);

  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_CHARS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REPL_CODE = 2'd2;

  localparam logic [1:0] MODE_UTF16 = 2'd0;
  localparam logic [1:0] MODE_LATIN = 2'd1;
  localparam logic [1:0] MODE_FAT = 2'd2;

  localparam logic [1:0] MODE_RESET = MODE_UTF16;
  localparam logic [CHAR_W-1:0] MAX_CHARS_RESET = 16'd255;
  localparam logic [CHAR_W-1:0] REPL_CODE_RESET = 16'd95;

  typedef struct packed {
    logic [1:0]        mode;
    logic [CHAR_W-1:0] max_chars;
    logic [CHAR_W-1:0] repl_code;
  } cfg_t;

  typedef struct packed {
    logic [BYTE_W-1:0] in_byte;
    logic              first;
    logic              reserved;
  } in_item_t;

  typedef struct packed {
    logic     valid;
    in_item_t item;
  } q_head_t;

  // The characters that a FAT file name cannot hold: < > : " \ | ? *
  function automatic logic fat_banned(input logic [BYTE_W-1:0] b);
    return (b == 8'h3C) || (b == 8'h3E) || (b == 8'h3A) || (b == 8'h22) ||
           (b == 8'h5C) || (b == 8'h7C) || (b == 8'h3F) || (b == 8'h2A);
  endfunction

endpackage

// ----- hw/rtl/u8d_stream_if.sv -----
`timescale 1ns / 1ps

interface u8d_in_if;
  logic                        valid;
  logic                        ready;
  logic [u8d_pkg::BYTE_W-1:0]  in_byte;
  logic                        first;

  modport source (output valid, output in_byte, output first, input ready);
  modport sink (input valid, input in_byte, input first, output ready);
endinterface

interface u8d_out_if;
  logic                        valid;
  logic                        ready;
  logic [u8d_pkg::CHAR_W-1:0]  char_code;
  logic                        is_terminator;
  logic [u8d_pkg::COUNT_W-1:0] char_count;
  logic                        last;

  modport source (output valid, output char_code, output is_terminator,
                  output char_count, output last, input ready);
  modport sink (input valid, input char_code, input is_terminator,
                input char_count, input last, output ready);
endinterface

// ----- hw/rtl/u8d_front.sv -----
`timescale 1ns / 1ps

module u8d_front #(
  parameter int unsigned QUEUE_DEPTH = u8d_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  u8d_in_if.sink            in_ch,
  input  logic              pop,
  output u8d_pkg::q_head_t  head
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  u8d_pkg::in_item_t q_r [QUEUE_DEPTH];
  u8d_pkg::in_item_t item;
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  fill_r, fill_nxt;
  logic              push;
  logic              do_pop;

  assign in_ch.ready = (fill_r != CNT_W'(QUEUE_DEPTH));
  assign push = in_ch.valid && in_ch.ready;
  assign do_pop = pop && (fill_r != '0);

  always_comb begin
    item.in_byte = in_ch.in_byte;
    item.first = in_ch.first;
    item.reserved = u8d_pkg::fat_banned(in_ch.in_byte);
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt = fill_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    unique case ({push, do_pop})
      2'b10: fill_nxt = fill_r + CNT_W'(1);
      2'b01: fill_nxt = fill_r - CNT_W'(1);
      default: fill_nxt = fill_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r <= fill_nxt;
    end
    if (push) begin
      q_r[wr_ptr_r] <= item;
    end
  end

  assign head.valid = (fill_r != '0);
  assign head.item = q_r[rd_ptr_r];

endmodule

// ----- hw/rtl/u8d_back.sv -----
`timescale 1ns / 1ps

module u8d_back (
  input  logic              clk,
  input  logic              rst_n,
  input  u8d_pkg::cfg_t     cfg,
  input  u8d_pkg::q_head_t  head,
  output logic              pop,
  u8d_out_if.source         out_ch
);

  localparam int unsigned IDX_W = u8d_pkg::PEND_IDX_W;
  localparam int unsigned CNT_W = u8d_pkg::PEND_CNT_W;
  localparam int unsigned CW = u8d_pkg::CHAR_W;
  localparam int unsigned KW = u8d_pkg::COUNT_W;

  typedef enum logic [1:0] {PH_START, PH_FLUSH, PH_FRESH, PH_TERM} phase_t;

  function automatic logic [CNT_W-1:0] lead_need(input logic [7:0] lead);
    logic [CNT_W-1:0] k;
    logic             run;
    k = '0;
    run = 1'b1;
    for (int i = 6; i >= 0; i--) begin
      if (run && lead[i]) begin
        k = k + CNT_W'(1);
      end else begin
        run = 1'b0;
      end
    end
    return k;
  endfunction

  phase_t           phase_r, phase_nxt;
  logic [7:0]       lead_r, lead_nxt;
  logic [7:0]       pend_r [u8d_pkg::PEND_DEPTH];
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [KW-1:0]    chars_r, chars_nxt;
  logic [CW-1:0]    bytes_r, bytes_nxt;
  logic             ended_r, ended_nxt;
  logic [7:0]       cur_r, cur_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic [CW-1:0]    out_code_r, out_code_nxt;
  logic             out_term_r, out_term_nxt;
  logic [KW-1:0]    out_count_r, out_count_nxt;
  logic             out_last_r, out_last_nxt;

  logic             pend_we;
  logic [IDX_W-1:0] pend_wi;
  logic [7:0]       pend_wd;

  logic             slot_free;
  logic             first;
  logic             ended_eff;
  logic [7:0]       lead_eff;
  logic [KW-1:0]    chars_base;
  logic [CW-1:0]    bytes_eff;
  logic [7:0]       bf;
  logic [CNT_W-1:0] need;
  logic [CW-1:0]    seq_code;
  logic [KW-1:0]    term_cnt;

  logic             emit;
  logic             dv_fire;
  logic             dv_chain;
  logic             chain_more;
  logic [7:0]       chain_cur;
  logic [CW-1:0]    dv_c;
  logic [CW-1:0]    dv_out;
  logic [KW-1:0]    dv_inc;
  logic             dv_hit;

  assign slot_free = !out_valid_r || out_ch.ready;
  assign first = head.item.first;
  assign ended_eff = first ? 1'b0 : ended_r;
  assign lead_eff = first ? 8'h00 : lead_r;
  assign chars_base = (phase_r == PH_START && first) ? '0 : chars_r;
  assign bytes_eff = first ? '0 : bytes_r;
  assign term_cnt = (cfg.mode == u8d_pkg::MODE_LATIN) ? chars_base : chars_base + KW'(1);

  always_comb begin
    bf = head.item.in_byte;
    if (cfg.mode == u8d_pkg::MODE_FAT) begin
      if (bytes_eff >= cfg.max_chars) begin
        bf = 8'h00;
      end else if (head.item.reserved) begin
        bf = cfg.repl_code[7:0];
      end
    end
  end

  assign need = lead_need(lead_r);

  always_comb begin
    if (need == CNT_W'(1)) begin
      seq_code = {5'b0, lead_r[4:0], bf[5:0]};
    end else if (need == CNT_W'(2)) begin
      seq_code = {lead_r[3:0], pend_r[0][5:0], bf[5:0]};
    end else begin
      seq_code = cfg.repl_code;
    end
  end

  assign dv_inc = chars_base + KW'(1);
  assign dv_hit = dv_inc >= {1'b0, cfg.max_chars};
  assign dv_out = (cfg.mode != u8d_pkg::MODE_LATIN) ? dv_c :
                  {8'h00, (dv_c > 16'h00FF) ? cfg.repl_code[7:0] : dv_c[7:0]};

  always_comb begin
    phase_nxt = phase_r;
    lead_nxt = lead_r;
    cnt_nxt = cnt_r;
    idx_nxt = idx_r;
    chars_nxt = chars_r;
    bytes_nxt = bytes_r;
    ended_nxt = ended_r;
    cur_nxt = cur_r;
    pend_we = 1'b0;
    pend_wi = cnt_r[IDX_W-1:0];
    pend_wd = bf;
    pop = 1'b0;
    emit = 1'b0;
    out_code_nxt = out_code_r;
    out_term_nxt = out_term_r;
    out_count_nxt = out_count_r;
    out_last_nxt = out_last_r;
    dv_fire = 1'b0;
    dv_chain = 1'b0;
    chain_more = 1'b0;
    chain_cur = cur_r;
    dv_c = '0;

    unique case (phase_r)
      PH_START: begin
        if (head.valid && slot_free) begin
          pop = 1'b1;
          if (!ended_eff) begin
            ended_nxt = 1'b0;
            lead_nxt = lead_eff;
            chars_nxt = chars_base;
            bytes_nxt = bytes_eff;
            if (chars_base >= {1'b0, cfg.max_chars}) begin
              emit = 1'b1;
              out_code_nxt = '0;
              out_term_nxt = 1'b1;
              out_count_nxt = term_cnt;
              out_last_nxt = 1'b1;
              ended_nxt = 1'b1;
              lead_nxt = 8'h00;
            end else begin
              bytes_nxt = (bytes_eff == '1) ? bytes_eff : bytes_eff + CW'(1);
              if (lead_eff != 8'h00) begin
                if (bf[7:6] == 2'b10) begin
                  if (({1'b0, cnt_r} + (CNT_W + 1)'(1)) >= {1'b0, need}) begin
                    lead_nxt = 8'h00;
                    dv_fire = 1'b1;
                    dv_c = seq_code;
                  end else begin
                    pend_we = 1'b1;
                    cnt_nxt = cnt_r + CNT_W'(1);
                  end
                end else begin
                  // Broken sequence: the lead goes out raw, then the stored bytes, then the new byte.
                  lead_nxt = 8'h00;
                  cur_nxt = bf;
                  idx_nxt = '0;
                  dv_fire = 1'b1;
                  dv_chain = 1'b1;
                  dv_c = {8'h00, lead_eff};
                  chain_more = (cnt_r != '0);
                  chain_cur = bf;
                end
              end else if (bf[7:6] == 2'b11) begin
                lead_nxt = bf;
                cnt_nxt = '0;
              end else begin
                dv_fire = 1'b1;
                dv_c = {8'h00, bf};
              end
            end
          end
        end
      end
      PH_FLUSH: begin
        if (slot_free) begin
          dv_fire = 1'b1;
          dv_chain = 1'b1;
          dv_c = {8'h00, pend_r[idx_r]};
          chain_more = (CNT_W'(idx_r) + CNT_W'(1)) < cnt_r;
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      PH_FRESH: begin
        if (slot_free) begin
          dv_fire = 1'b1;
          dv_c = {8'h00, cur_r};
        end
      end
      PH_TERM: begin
        if (slot_free) begin
          emit = 1'b1;
          out_code_nxt = '0;
          out_term_nxt = 1'b1;
          out_count_nxt = term_cnt;
          out_last_nxt = 1'b1;
          ended_nxt = 1'b1;
          lead_nxt = 8'h00;
          phase_nxt = PH_START;
        end
      end
      default: phase_nxt = PH_START;
    endcase

    if (dv_fire) begin
      emit = 1'b1;
      phase_nxt = PH_START;
      if (dv_c == '0 && !dv_chain) begin
        out_code_nxt = '0;
        out_term_nxt = 1'b1;
        out_count_nxt = term_cnt;
        out_last_nxt = 1'b1;
        ended_nxt = 1'b1;
        lead_nxt = 8'h00;
      end else begin
        out_code_nxt = dv_out;
        out_term_nxt = 1'b0;
        out_count_nxt = '0;
        out_last_nxt = 1'b0;
        chars_nxt = dv_inc;
        priority if (dv_hit) begin
          phase_nxt = PH_TERM;
        end else if (!dv_chain) begin
          out_last_nxt = 1'b1;
        end else if (chain_more) begin
          phase_nxt = PH_FLUSH;
        end else if (chain_cur[7:6] == 2'b11) begin
          lead_nxt = chain_cur;
          cnt_nxt = '0;
          out_last_nxt = 1'b1;
        end else begin
          phase_nxt = PH_FRESH;
        end
      end
    end

    if (emit) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && !out_ch.ready;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_START;
      lead_r <= 8'h00;
      cnt_r <= '0;
      idx_r <= '0;
      chars_r <= '0;
      bytes_r <= '0;
      ended_r <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      lead_r <= lead_nxt;
      cnt_r <= cnt_nxt;
      idx_r <= idx_nxt;
      chars_r <= chars_nxt;
      bytes_r <= bytes_nxt;
      ended_r <= ended_nxt;
      out_valid_r <= out_valid_nxt;
    end
    if (pend_we) begin
      pend_r[pend_wi] <= pend_wd;
    end
    cur_r <= cur_nxt;
    out_code_r <= out_code_nxt;
    out_term_r <= out_term_nxt;
    out_count_r <= out_count_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.char_code = out_code_r;
  assign out_ch.is_terminator = out_term_r;
  assign out_ch.char_count = out_count_r;
  assign out_ch.last = out_last_r;

endmodule

// ----- hw/rtl/utf8_to_utf16_stream_decoder_unit.sv -----
`timescale 1ns / 1ps

// UTF-8 to 16-bit character decoder, one byte word in, one character word out.
// The in_ch channel takes a byte and a first flag that opens a new string; the
// out_ch channel returns characters, and a terminator word that carries the
// character count. Each byte gives zero or more words, and the final word of a
// byte has last set. The user writes the cfg port (mode, max_chars and
// replacement_code) only while the block is idle; the block does not enforce it.
// A byte is accepted into a QUEUE_DEPTH-entry queue (four by default) and
// classified there; the decoder behind it takes one queued byte per cycle
// while not flushing and with its output register free, and registers its
// first word. While out_ch is ready, a byte that gives at most one word
// sustains one byte per cycle and a broken sequence is flushed one word per
// cycle, holding the decoder until all its words (up to nine) are out; the
// queue keeps taking bytes meanwhile. When out_ch stalls, the output register
// holds its word, the decoder waits and the queue fills, after which in_ch.ready
// drops. Reset empties the queue and the output register, restores the register
// defaults, and ignores bytes until one arrives with first set.

module utf8_to_utf16_stream_decoder_unit #(
  parameter int unsigned QUEUE_DEPTH = u8d_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  u8d_in_if.sink                           in_ch,
  u8d_out_if.source                        out_ch,
  input  logic                             cfg_we,
  input  logic [u8d_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [u8d_pkg::CFG_DATA_W-1:0]   cfg_data
);

  logic [1:0]                   mode_r, mode_nxt;
  logic [u8d_pkg::CHAR_W-1:0]   max_chars_r, max_chars_nxt;
  logic [u8d_pkg::CHAR_W-1:0]   repl_r, repl_nxt;
  u8d_pkg::cfg_t                cfg;
  u8d_pkg::q_head_t             head;
  logic                         pop;

  always_comb begin
    mode_nxt = mode_r;
    max_chars_nxt = max_chars_r;
    repl_nxt = repl_r;
    if (cfg_we) begin
      unique case (cfg_index)
        u8d_pkg::CFG_MODE: mode_nxt = cfg_data[1:0];
        u8d_pkg::CFG_MAX_CHARS: max_chars_nxt = cfg_data[u8d_pkg::CHAR_W-1:0];
        u8d_pkg::CFG_REPL_CODE: repl_nxt = cfg_data[u8d_pkg::CHAR_W-1:0];
        default: mode_nxt = mode_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= u8d_pkg::MODE_RESET;
      max_chars_r <= u8d_pkg::MAX_CHARS_RESET;
      repl_r <= u8d_pkg::REPL_CODE_RESET;
    end else begin
      mode_r <= mode_nxt;
      max_chars_r <= max_chars_nxt;
      repl_r <= repl_nxt;
    end
  end

  always_comb begin
    cfg.mode = mode_r;
    cfg.max_chars = max_chars_r;
    cfg.repl_code = repl_r;
  end

  u8d_front #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .pop   (pop),
    .head  (head)
  );

  u8d_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .head   (head),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule

// ----- hw/rtl/u8d_checker.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"

module u8d_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [u8d_pkg::CHAR_W-1:0]        out_char_code,
  input logic                              out_is_term,
  input logic [u8d_pkg::COUNT_W-1:0]       out_char_count,
  input logic                              out_last
);

  `U8D_ASSERT(a_valid_hold, clk, rst_n, out_valid && !out_ready |=> out_valid, "word dropped while stalled")
  `U8D_ASSERT(a_data_hold, clk, rst_n, out_valid && !out_ready |=> $stable(out_char_code) && $stable(out_char_count) && $stable(out_is_term) && $stable(out_last), "word changed while stalled")
  `U8D_ASSERT(a_term_shape, clk, rst_n, out_valid && out_is_term |-> (out_char_code == '0) && out_last, "terminator must carry code zero and close its byte")
  `U8D_ASSERT(a_char_count, clk, rst_n, out_valid && !out_is_term |-> out_char_count == '0, "character word with nonzero count")
  `U8D_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |=> !out_valid, "output valid right after reset")

endmodule

bind utf8_to_utf16_stream_decoder_unit u8d_checker u_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_char_code  (out_ch.char_code),
  .out_is_term    (out_ch.is_terminator),
  .out_char_count (out_ch.char_count),
  .out_last       (out_ch.last)
);

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 8;
  localparam int MAX_WORDS = 9;
  localparam int CONT_DEPTH = 6;
  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam logic [7:0] FAT_BYTES [8] = '{"<", ">", ":", "\"", "\\", "|", "?", "*"};

  typedef struct packed {
    logic [u8d_pkg::BYTE_W-1:0] value;
    logic                       first;
  } byte_word_t;

  typedef struct packed {
    logic [u8d_pkg::CHAR_W-1:0]  code;
    logic                        term;
    logic [u8d_pkg::COUNT_W-1:0] count;
    logic                        last;
  } char_word_t;

  logic                           clk;
  logic                           rst_n;
  logic                           cfg_we;
  logic [u8d_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [u8d_pkg::CFG_DATA_W-1:0] cfg_data;

  u8d_in_if in_ch();
  u8d_out_if out_ch();

  utf8_to_utf16_stream_decoder_unit dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  byte_word_t byte_queue[$];
  char_word_t expected_chars[$];
  byte_word_t next_word;
  int         errors = 0;
  int         cycle_count = 0;
  int         item_count = 0;
  int         send_idle_pct = 0;
  int         recv_idle_pct = 0;
  logic       first_flag = 1'b0;

  // Decoder state mirrored for prediction.
  logic [1:0]  cur_mode;
  logic [15:0] cur_max;
  logic [15:0] cur_repl;
  logic [7:0]  seq_lead;
  logic [7:0]  seq_cont [CONT_DEPTH];
  int          seq_cnt;
  int          n_chars;
  int          n_bytes;
  logic        str_done;
  int          step_words;

  function automatic void emit(logic [15:0] code, logic term, logic [16:0] count);
    if (step_words < MAX_WORDS) begin
      expected_chars.push_back('{code: code, term: term, count: count, last: 1'b0});
    end
    step_words++;
  endfunction

  function automatic void close_string();
    int total;
    total = (cur_mode == u8d_pkg::MODE_LATIN) ? n_chars : n_chars + 1;
    emit(16'h0000, 1'b1, total[16:0]);
    str_done = 1'b1;
    seq_lead = 8'h00;
    seq_cnt = 0;
  endfunction

  function automatic void put_char(int c);
    if (c == 0) begin
      close_string();
      return;
    end
    if (cur_mode == u8d_pkg::MODE_LATIN) begin
      if (c > 255) c = int'(cur_repl);
      c = c & 255;
    end
    emit(c[15:0], 1'b0, 17'd0);
    n_chars++;
    if (n_chars >= cur_max) close_string();
  endfunction

  function automatic void start_byte(logic [7:0] b);
    if (b[7:6] == 2'b11) begin
      seq_lead = b;
      seq_cnt = 0;
    end else begin
      put_char(int'(b));
    end
  endfunction

  function automatic int lead_conts(logic [7:0] b);
    int k;
    k = 0;
    for (int i = 6; i >= 0 && b[i]; i--) k++;
    return k;
  endfunction

  function automatic void continue_seq(logic [7:0] b);
    logic [7:0] lead;
    int         cnt;
    int         need;
    int         c;
    lead = seq_lead;
    cnt = seq_cnt;
    if (b[7:6] == 2'b10) begin
      need = lead_conts(lead);
      if (cnt + 1 >= need) begin
        if (need == 1) c = int'({lead[4:0], b[5:0]});
        else if (need == 2) c = int'({lead[3:0], seq_cont[0][5:0], b[5:0]});
        else c = int'(cur_repl);
        seq_lead = 8'h00;
        seq_cnt = 0;
        put_char(c);
      end else if (cnt < CONT_DEPTH) begin
        seq_cont[cnt] = b;
        seq_cnt = cnt + 1;
      end
      return;
    end
    seq_lead = 8'h00;
    seq_cnt = 0;
    put_char(int'(lead));
    for (int i = 0; i < cnt && !str_done; i++) put_char(int'(seq_cont[i]));
    if (!str_done) start_byte(b);
  endfunction

  function automatic void decode_byte(logic [7:0] b, logic f);
    int prior_size;
    prior_size = expected_chars.size();
    step_words = 0;
    if (f) begin
      n_chars = 0;
      n_bytes = 0;
      seq_lead = 8'h00;
      seq_cnt = 0;
      str_done = 1'b0;
    end
    if (str_done) return;
    if (n_chars >= cur_max) begin
      close_string();
    end else begin
      if (cur_mode == u8d_pkg::MODE_FAT) begin
        if (n_bytes >= cur_max) b = 8'h00;
        else if (b inside {"<", ">", ":", "\"", "\\", "|", "?", "*"}) b = cur_repl[7:0];
      end
      if (n_bytes < 16'hFFFF) n_bytes++;
      if (seq_lead != 8'h00) continue_seq(b);
      else start_byte(b);
    end
    if (expected_chars.size() > prior_size) begin
      expected_chars[expected_chars.size()-1].last = 1'b1;
    end
  endfunction

  task automatic check_word();
    char_word_t want;
    if (expected_chars.size() == 0) begin
      $error("unexpected word: char_code %h is_terminator %b char_count %0d last %b",
             out_ch.char_code, out_ch.is_terminator, out_ch.char_count, out_ch.last);
      errors++;
      return;
    end
    want = expected_chars.pop_front();
    if (out_ch.char_code !== want.code) begin
      $error("char_code: expected %h, got %h", want.code, out_ch.char_code);
      errors++;
    end
    if (out_ch.is_terminator !== want.term) begin
      $error("is_terminator: expected %b, got %b", want.term, out_ch.is_terminator);
      errors++;
    end
    if (out_ch.char_count !== want.count) begin
      $error("char_count: expected %0d, got %0d", want.count, out_ch.char_count);
      errors++;
    end
    if (out_ch.last !== want.last) begin
      $error("last: expected %b, got %b", want.last, out_ch.last);
      errors++;
    end
  endtask

  function automatic void put_byte(logic [7:0] v);
    byte_queue.push_back('{value: v, first: first_flag});
    first_flag = 1'b0;
    item_count++;
  endfunction

  function automatic void gen_string();
    int         n;
    int         kind;
    int         conts;
    logic [7:0] lead;
    first_flag = 1'b1;
    n = $urandom_range(1, 12);
    for (int k = 0; k < n; k++) begin
      kind = $urandom_range(0, 99);
      if (kind < 35) begin
        put_byte(8'($urandom_range(1, 127)));
      end else if (kind < 42) begin
        put_byte(FAT_BYTES[$urandom_range(0, 7)]);
      end else if (kind < 92) begin
        if (kind < 56) lead = 8'hC0 | 8'($urandom_range(0, 31));
        else if (kind < 68) lead = 8'hE0 | 8'($urandom_range(0, 15));
        else lead = 8'hC0 | 8'($urandom_range(0, 63));
        conts = lead_conts(lead);
        if (kind >= 78) conts = $urandom_range(0, conts - 1);
        put_byte(lead);
        repeat (conts) put_byte(8'h80 | 8'($urandom_range(0, 63)));
      end else begin
        put_byte(8'($urandom_range(0, 255)));
      end
    end
    if ($urandom_range(0, 9) != 0) put_byte(8'h00);
  endfunction

  task automatic write_reg(input logic [u8d_pkg::CFG_IDX_W-1:0] idx,
                           input logic [u8d_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      u8d_pkg::CFG_MODE: cur_mode = val[1:0];
      u8d_pkg::CFG_MAX_CHARS: cur_max = val;
      u8d_pkg::CFG_REPL_CODE: cur_repl = val;
      default: ;
    endcase
  endtask

  task automatic configure(input logic [1:0] m, input logic [15:0] mx, input logic [15:0] rc);
    write_reg(u8d_pkg::CFG_MODE, {14'd0, m});
    write_reg(u8d_pkg::CFG_MAX_CHARS, mx);
    write_reg(u8d_pkg::CFG_REPL_CODE, rc);
  endtask

  task automatic settle();
    do @(posedge clk);
    while (byte_queue.size() != 0 || in_ch.valid || expected_chars.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic random_phase(input int n);
    int          target;
    int          r;
    logic [15:0] mx;
    logic [15:0] rc;
    r = $urandom_range(0, 19);
    if (r == 0) mx = 16'd0;
    else if (r == 1) mx = 16'hFFFF;
    else if (r == 2) mx = 16'($urandom_range(0, 65535));
    else mx = 16'($urandom_range(1, 40));
    r = $urandom_range(0, 19);
    if (r == 0) rc = 16'd0;
    else if (r < 4) rc = 16'($urandom_range(0, 255));
    else rc = 16'($urandom_range(0, 65535));
    configure(2'($urandom_range(0, 3)), mx, rc);
    target = item_count + n;
    while (item_count < target) gen_string();
    settle();
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[utf8_to_utf16_stream_decoder_unit] ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) decode_byte(in_ch.in_byte, in_ch.first);
      if (!in_ch.valid || in_ch.ready) begin
        if (byte_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          next_word = byte_queue.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.in_byte <= next_word.value;
          in_ch.first <= next_word.first;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) check_word();
      out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = u8d_pkg::CFG_MODE;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.in_byte = '0;
    in_ch.first = 1'b0;
    out_ch.ready = 1'b0;
    cur_mode = u8d_pkg::MODE_RESET;
    cur_max = u8d_pkg::MAX_CHARS_RESET;
    cur_repl = u8d_pkg::REPL_CODE_RESET;
    seq_lead = 8'h00;
    seq_cnt = 0;
    n_chars = 0;
    n_bytes = 0;
    str_done = 1'b1;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 35;
    recv_idle_pct = 59;

    // Reset settings: a byte before any string start is dropped, then
    // two- and three-byte forms, a broken sequence, a stray continuation
    // byte, and a decoded zero that closes the string.
    put_byte(8'h41);
    first_flag = 1'b1;
    put_byte(8'hC3);
    put_byte(8'hA9);
    put_byte(8'hE2);
    put_byte(8'h82);
    put_byte(8'hAC);
    put_byte(8'hE2);
    put_byte(8'h82);
    put_byte(8'h7F);
    put_byte(8'h80);
    put_byte(8'hC0);
    put_byte(8'h80);
    settle();

    // Latin output with the limit reached in the middle of a flush.
    configure(u8d_pkg::MODE_LATIN, 16'd3, 16'h1234);
    first_flag = 1'b1;
    put_byte(8'hE2);
    put_byte(8'h82);
    put_byte(8'hAC);
    put_byte(8'hF0);
    put_byte(8'h81);
    put_byte(8'h82);
    put_byte(8'h00);
    settle();

    // A zero limit closes the string on its first byte.
    configure(u8d_pkg::MODE_FAT, 16'd0, 16'h0000);
    first_flag = 1'b1;
    put_byte(8'h3C);
    settle();

    // With a zero replacement code a reserved byte ends the string, and
    // the byte limit turns a later byte into a terminator.
    write_reg(u8d_pkg::CFG_MAX_CHARS, 16'd3);
    first_flag = 1'b1;
    put_byte(8'h61);
    put_byte(8'h3C);
    first_flag = 1'b1;
    put_byte(8'hC3);
    put_byte(8'hA9);
    put_byte(8'h41);
    put_byte(8'h42);
    first_flag = 1'b1;
    put_byte(8'h62);
    put_byte(8'h63);
    settle();

    // The limit is lowered under an open string.
    write_reg(u8d_pkg::CFG_MAX_CHARS, 16'd1);
    put_byte(8'h64);
    settle();

    configure(MODE_SPARE, 16'hFFFF, 16'hFFFF);
    first_flag = 1'b1;
    put_byte(8'hF8);
    repeat (4) put_byte(8'hBF);
    put_byte(8'hFF);
    repeat (6) put_byte(8'h80);
    put_byte(8'h00);
    settle();

    for (int r = 0; r < 3; r++) begin
      send_idle_pct = (r == 0) ? 35 : (r == 1) ? 59 : 0;
      recv_idle_pct = (r == 0) ? 59 : (r == 1) ? 35 : 0;
      random_phase(40);
      random_phase(40);
    end

    if (errors == 0 && expected_chars.size() == 0) begin
      $display("[utf8_to_utf16_stream_decoder_unit] OK");
    end else begin
      $display("[utf8_to_utf16_stream_decoder_unit] ERROR");
    end
    $finish;
  end

endmodule
